### hdl/assert_macros.svh
// assertion macros shared by the serial mouse fifo modules
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// check on every rising edge outside reset
`define SRM_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// check on every rising edge, reset included
`define SRM_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

### hdl/srm_pkg.sv
// types and constants of the serial mouse packet fifo
package srm_pkg;

  // request codes
  localparam logic [2:0] REQ_MOVE = 3'd0;
  localparam logic [2:0] REQ_DOWN = 3'd1;
  localparam logic [2:0] REQ_UP   = 3'd2;
  localparam logic [2:0] REQ_MCR  = 3'd3;
  localparam logic [2:0] REQ_POLL = 3'd4;

  // button codes
  localparam logic [1:0] BTN_LEFT  = 2'd0;
  localparam logic [1:0] BTN_RIGHT = 2'd1;

  // packet and reset bytes
  localparam logic [7:0] PKT_SYNC   = 8'h40;
  localparam logic [7:0] ID_BYTE    = 8'h4D;
  localparam logic [1:0] CTRL_ARMED = 2'b11;

  // which byte of a packet goes into the fifo
  typedef enum logic [1:0] {
    SEL_HEAD = 2'd0,
    SEL_DX   = 2'd1,
    SEL_DY   = 2'd2
  } byte_sel_t;

  // controller to datapath
  typedef struct packed {
    logic      load;
    logic      push;
    byte_sel_t sel;
    logic      mcr;
    logic      pop;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic empty;
  } status_t;

endpackage

### hdl/srm_ram.sv
// generic single write port ram with registered read
module srm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### hdl/srm_ctrl.sv
// controller state machine of the serial mouse fifo
`include "assert_macros.svh"

module srm_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [2:0]       req_type,
  input  logic             uart_busy,
  input  srm_pkg::status_t status,
  output srm_pkg::cmd_t    cmd,
  output logic             busy,
  output logic             rx_valid
);
  import srm_pkg::*;

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_PUSH0 = 7'b0000010,
    S_PUSH1 = 7'b0000100,
    S_PUSH2 = 7'b0001000,
    S_MCR   = 7'b0010000,
    S_READ  = 7'b0100000,
    S_OUT   = 7'b1000000
  } state_t;

  state_t state, state_next;
  logic   accept;

  assign accept   = start && (state == S_IDLE);
  assign busy     = (state != S_IDLE);
  assign rx_valid = (state == S_OUT);

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (start) begin
          case (req_type)
            REQ_MOVE, REQ_DOWN, REQ_UP: state_next = S_PUSH0;
            REQ_MCR:                    state_next = S_MCR;
            REQ_POLL: begin
              if (!uart_busy && !status.empty) state_next = S_READ;
            end
            default:                    state_next = S_IDLE;
          endcase
        end
      end
      S_PUSH0: state_next = S_PUSH1;
      S_PUSH1: state_next = S_PUSH2;
      S_PUSH2: state_next = S_IDLE;
      S_MCR:   state_next = S_IDLE;
      S_READ:  state_next = S_OUT;
      S_OUT:   state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    cmd.sel  = SEL_HEAD;
    cmd.load = accept;
    case (state)
      S_PUSH0: cmd.push = 1'b1;
      S_PUSH1: begin
        cmd.push = 1'b1;
        cmd.sel  = SEL_DX;
      end
      S_PUSH2: begin
        cmd.push = 1'b1;
        cmd.sel  = SEL_DY;
      end
      S_MCR:   cmd.mcr = 1'b1;
      S_READ:  cmd.pop = 1'b1;
      default: cmd.push = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  `SRM_ASSERT(a_out_after_read, rx_valid |-> $past(state == S_READ), "result without read")
  `SRM_ASSERT(a_poll_empty_quiet, (accept && req_type == REQ_POLL && status.empty) |=> !busy, "poll of empty fifo started a read")
  `SRM_ASSERT(a_packet_three, (state == S_PUSH0) |=> (state == S_PUSH1) ##1 (state == S_PUSH2), "packet push sequence broken")

endmodule

### hdl/srm_dp.sv
// datapath of the serial mouse fifo: request registers, button state, byte fifo
`include "assert_macros.svh"

module srm_dp #(
  parameter int QUEUE_DEPTH = 16
) (
  input  logic             clk,
  input  logic             rst,
  input  srm_pkg::cmd_t    cmd,
  input  logic [2:0]       req_type,
  input  logic [7:0]       dx,
  input  logic [7:0]       dy,
  input  logic [1:0]       button,
  input  logic [7:0]       mcr_value,
  output srm_pkg::status_t status,
  output logic [7:0]       rx_byte
);
  import srm_pkg::*;

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QUEUE_DEPTH);

  logic [7:0]       dx_q;
  logic [7:0]       dy_q;
  logic [7:0]       mcr_q;
  logic [1:0]       button_bits;
  logic [1:0]       last_ctrl_bits;
  logic [PTR_W-1:0] head;
  logic [PTR_W-1:0] tail;
  logic [CNT_W-1:0] count;

  logic             mcr_reset;
  logic             we;
  logic [PTR_W-1:0] waddr;
  logic [7:0]       wdata;
  logic [7:0]       pkt_byte;

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    ptr_inc = (p == PTR_LAST) ? '0 : p + PTR_W'(1);
  endfunction

  assign mcr_reset = cmd.mcr && (last_ctrl_bits != CTRL_ARMED)
                     && (mcr_q[1:0] == CTRL_ARMED);

  always_comb begin
    case (cmd.sel)
      SEL_HEAD: pkt_byte = PKT_SYNC | {2'b00, button_bits, dy_q[7:6], dx_q[7:6]};
      SEL_DX:   pkt_byte = {2'b00, dx_q[5:0]};
      SEL_DY:   pkt_byte = {2'b00, dy_q[5:0]};
      default:  pkt_byte = PKT_SYNC;
    endcase
  end

  // id byte lands at head of a freshly emptied fifo
  assign we    = mcr_reset || (cmd.push && (count != CNT_FULL));
  assign waddr = mcr_reset ? head : tail;
  assign wdata = mcr_reset ? ID_BYTE : pkt_byte;

  assign status.empty = (count == '0);

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      dx_q  <= (req_type == REQ_MOVE) ? dx : 8'h00;
      dy_q  <= (req_type == REQ_MOVE) ? dy : 8'h00;
      mcr_q <= mcr_value;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      button_bits    <= '0;
      last_ctrl_bits <= '0;
      head           <= '0;
      tail           <= '0;
      count          <= '0;
    end else begin
      if (cmd.load && req_type == REQ_DOWN) begin
        if (button == BTN_LEFT)  button_bits[1] <= 1'b1;
        if (button == BTN_RIGHT) button_bits[0] <= 1'b1;
      end
      if (cmd.load && req_type == REQ_UP) begin
        if (button == BTN_LEFT)  button_bits[1] <= 1'b0;
        if (button == BTN_RIGHT) button_bits[0] <= 1'b0;
      end
      if (cmd.mcr) begin
        last_ctrl_bits <= mcr_q[1:0];
      end
      if (mcr_reset) begin
        tail  <= ptr_inc(head);
        count <= CNT_W'(1);
      end else if (we) begin
        tail  <= ptr_inc(tail);
        count <= count + CNT_W'(1);
      end else if (cmd.pop) begin
        head  <= ptr_inc(head);
        count <= count - CNT_W'(1);
      end
    end
  end

  srm_ram #(
    .WIDTH(8),
    .DEPTH(QUEUE_DEPTH)
  ) u_ram (
    .clk  (clk),
    .we   (we),
    .waddr(waddr),
    .wdata(wdata),
    .re   (cmd.pop),
    .raddr(head),
    .rdata(rx_byte)
  );

  `SRM_ASSERT(a_count_bound, count <= CNT_FULL, "fifo count beyond depth")
  `SRM_ASSERT(a_pop_nonempty, cmd.pop |-> (count != '0), "pop from empty fifo")
  `SRM_ASSERT(a_mcr_one_byte, mcr_reset |=> (count == CNT_W'(1)), "mouse reset left wrong count")

endmodule

### hdl/serial_mouse_packet_fifo.sv
// top level of the emulated serial mouse packet fifo
//
// command channel: an item transfers at a rising edge with start high and
// busy low; req_type selects move, button down, button up, modem control
// write or poll, and the other fields are sampled at that edge
// a move or button request queues a 3-byte packet, one byte per cycle:
// busy in states S_PUSH0, S_PUSH1 and S_PUSH2, so no new item is taken before
// the packet is queued; bytes that find the fifo full are dropped, so a packet may be cut short
// a modem control write is busy only in state S_MCR; when its low bits arm from
// another value the fifo is emptied and the id byte 'M' queued
// poll with uart_busy low and a nonempty fifo: ram read in state S_READ,
// rx_byte shown with rx_valid in state S_OUT, then idle again
// any other poll, or an unknown code, returns to idle at once, no result
// each result is on rx_byte for exactly one cycle; the receiver cannot stall
// reset (rst, synchronous) empties the fifo and clears button and modem
// state; the fifo ram itself is not cleared
//
module serial_mouse_packet_fifo #(
  parameter int QUEUE_DEPTH = 16
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  logic [2:0]        req_type,
  input  logic signed [7:0] dx,
  input  logic signed [7:0] dy,
  input  logic [1:0]        button,
  input  logic [7:0]        mcr_value,
  input  logic              uart_busy,
  output logic [7:0]        rx_byte,
  output logic              rx_valid
);
  import srm_pkg::*;

  cmd_t    cmd;
  status_t status;

  // sequencing of pushes, modem control and pops
  srm_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .req_type (req_type),
    .uart_busy(uart_busy),
    .status   (status),
    .cmd      (cmd),
    .busy     (busy),
    .rx_valid (rx_valid)
  );

  // packet formatting and byte fifo
  srm_dp #(
    .QUEUE_DEPTH(QUEUE_DEPTH)
  ) u_dp (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .req_type (req_type),
    .dx       ($unsigned(dx)),
    .dy       ($unsigned(dy)),
    .button   (button),
    .mcr_value(mcr_value),
    .status   (status),
    .rx_byte  (rx_byte)
  );

endmodule
